[rtl/ilp_pkg.sv]
// ----------------------------------------------------------------------------
// ilp_pkg
// Types and character constants shared by the integer literal parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

    localparam int ValueWidth = 63;
    localparam logic [ValueWidth-1:0] ValueMax = {ValueWidth{1'b1}};

    localparam logic [7:0] CharNul   = 8'h00;
    localparam logic [7:0] CharTab   = 8'h09;
    localparam logic [7:0] CharCr    = 8'h0D;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharSeven = 8'h37;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharUpA   = 8'h41;
    localparam logic [7:0] CharUpF   = 8'h46;
    localparam logic [7:0] CharUpX   = 8'h58;
    localparam logic [7:0] CharLowA  = 8'h61;
    localparam logic [7:0] CharLowF  = 8'h66;
    localparam logic [7:0] CharLowX  = 8'h78;

    localparam logic [7:0] DigitTen  = 8'd10;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_ZERO   = 3'd1,
        PH_HEXPFX = 3'd2,
        PH_BODY   = 3'd3,
        PH_TRAIL  = 3'd4,
        PH_ENDED  = 3'd5,
        PH_BAD    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef struct packed {
        logic       is_nul;
        logic       is_space;
        logic       is_zero;
        logic       is_x;
        logic       digit_ok;
        logic [3:0] digit;
    } char_class_t;

endpackage

[rtl/ilp_if.sv]
// ----------------------------------------------------------------------------
// ilp_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface ilp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface ilp_result_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [62:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface

[rtl/ilp_char_class.sv]
// ----------------------------------------------------------------------------
// ilp_char_class
// Classifies one character: whitespace, terminator, prefix marks, digit value.
// ----------------------------------------------------------------------------
module ilp_char_class (
    input  logic [7:0]           char_code,
    input  ilp_pkg::radix_t      radix,
    output ilp_pkg::char_class_t cls
);
    import ilp_pkg::*;

    logic       is_dec;
    logic       is_lo;
    logic       is_up;
    logic [7:0] diff;

    always_comb
    begin
        is_dec = char_code inside {[CharZero:CharNine]};
        is_lo  = char_code inside {[CharLowA:CharLowF]};
        is_up  = char_code inside {[CharUpA:CharUpF]};

        if (is_lo)
        begin
            diff = char_code - CharLowA + DigitTen;
        end
        else if (is_up)
        begin
            diff = char_code - CharUpA + DigitTen;
        end
        else
        begin
            diff = char_code - CharZero;
        end

        cls.is_nul   = (char_code == CharNul);
        cls.is_space = (char_code inside {[CharTab:CharCr]}) || (char_code == CharSpace);
        cls.is_zero  = (char_code == CharZero);
        cls.is_x     = (char_code == CharLowX) || (char_code == CharUpX);
        cls.digit    = diff[3:0];

        case (radix)
            RADIX_HEX: cls.digit_ok = is_dec || is_lo || is_up;
            RADIX_OCT: cls.digit_ok = char_code inside {[CharZero:CharSeven]};
            default:   cls.digit_ok = is_dec;
        endcase
    end

endmodule

[rtl/ilp_accum.sv]
// ----------------------------------------------------------------------------
// ilp_accum
// One accumulate step: value times base plus digit, saturating at the top.
// ----------------------------------------------------------------------------
module ilp_accum (
    input  logic [62:0]     acc,
    input  logic            saturated,
    input  ilp_pkg::radix_t radix,
    input  logic [3:0]      digit,
    output logic [62:0]     acc_next,
    output logic            saturated_next
);
    import ilp_pkg::*;

    localparam int ProdWidth = ValueWidth + 4;

    logic [ProdWidth-1:0] acc_wide;
    logic [ProdWidth-1:0] scaled;
    logic [ProdWidth-1:0] sum;

    always_comb
    begin
        acc_wide = {4'd0, acc};
        case (radix)
            RADIX_HEX: scaled = acc_wide << 4;
            RADIX_OCT: scaled = acc_wide << 3;
            default:   scaled = (acc_wide << 3) + (acc_wide << 1);
        endcase
        sum = scaled + {{(ProdWidth-4){1'b0}}, digit};

        if (saturated)
        begin
            acc_next       = acc;
            saturated_next = 1'b1;
        end
        else if (sum[ProdWidth-1:ValueWidth] != 4'd0)
        begin
            acc_next       = ValueMax;
            saturated_next = 1'b1;
        end
        else
        begin
            acc_next       = sum[ValueWidth-1:0];
            saturated_next = 1'b0;
        end
    end

endmodule

[rtl/integer_literal_parser_unit.sv]
// ----------------------------------------------------------------------------
// integer_literal_parser_unit
// Parses a C-style unsigned integer literal streamed one character per beat.
// ----------------------------------------------------------------------------
// chars: one character per beat, is_last marks the final beat of a string.
//   Whitespace around the body is skipped, 0x/0X selects hex, a leading 0
//   selects octal, otherwise decimal. A zero byte ends the string early.
// result: one beat per string, issued for the is_last beat: status 1 for a
//   character that is not a digit of the base or a non-space after trailing
//   whitespace (value 0), otherwise the value, saturated at 2^63-1.
// Throughput: one character per cycle unless a last beat stalls. The limit is
//   the accumulate loop (shift/add by the base, overflow check) in ilp_accum.
// Result path: a last character is taken into the input register, and its
//   result is written to the result register once that register is free.
// Stall: while a result waits on result.ready, a following last beat holds
//   in the input register and chars.ready drops; other beats keep flowing.
// Reset: rst_n clears the parse state and both valid flags; the next beat
//   starts a new string.
// ----------------------------------------------------------------------------
module integer_literal_parser_unit (
    input  logic         clk,
    input  logic         rst_n,
    ilp_char_if.sink     chars,
    ilp_result_if.source result
);
    import ilp_pkg::*;

    logic                  in_valid_reg;
    logic [7:0]            in_char_reg;
    logic                  in_last_reg;

    phase_t                phase_reg, phase_next;
    radix_t                radix_reg, radix_next;
    logic [ValueWidth-1:0] acc_reg, acc_next;
    logic                  sat_reg, sat_next;

    logic                  out_valid_reg;
    logic                  out_status_reg;
    logic [ValueWidth-1:0] out_value_reg;

    logic                  advance;
    radix_t                eff_radix;
    char_class_t           cls;
    logic                  do_acc;
    logic [ValueWidth-1:0] step_acc;
    logic                  step_sat;
    logic                  bad;

    // a last beat needs the result register free
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || result.ready);
    assign chars.ready = !in_valid_reg || advance;

    always_comb
    begin
        case (phase_reg)
            PH_LEAD: eff_radix = RADIX_DEC;
            PH_ZERO: eff_radix = RADIX_OCT;
            default: eff_radix = radix_reg;
        endcase
    end

    ilp_char_class u_class (
        .char_code (in_char_reg),
        .radix     (eff_radix),
        .cls       (cls)
    );

    ilp_accum u_accum (
        .acc            (acc_reg),
        .saturated      (sat_reg),
        .radix          (radix_next),
        .digit          (cls.digit),
        .acc_next       (step_acc),
        .saturated_next (step_sat)
    );

    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        do_acc     = 1'b0;

        case (phase_reg)
            PH_ENDED: ;
            PH_BAD:   ;
            PH_LEAD:
            begin
                if (cls.is_nul)
                begin
                    phase_next = PH_ENDED;
                end
                else if (cls.is_space)
                begin
                    phase_next = PH_LEAD;
                end
                else if (cls.is_zero)
                begin
                    phase_next = PH_ZERO;
                    radix_next = RADIX_OCT;
                end
                else if (!cls.digit_ok)
                begin
                    phase_next = PH_BAD;
                end
                else
                begin
                    phase_next = PH_BODY;
                    radix_next = RADIX_DEC;
                    do_acc     = 1'b1;
                end
            end
            PH_ZERO:
            begin
                if (cls.is_nul)
                begin
                    phase_next = PH_ENDED;
                end
                else if (cls.is_space)
                begin
                    phase_next = PH_TRAIL;
                end
                else if (cls.is_x)
                begin
                    phase_next = PH_HEXPFX;
                    radix_next = RADIX_HEX;
                end
                else if (!cls.digit_ok)
                begin
                    phase_next = PH_BAD;
                end
                else
                begin
                    phase_next = PH_BODY;
                    do_acc     = 1'b1;
                end
            end
            PH_HEXPFX, PH_BODY:
            begin
                if (cls.is_nul)
                begin
                    phase_next = PH_ENDED;
                end
                else if (cls.is_space)
                begin
                    phase_next = PH_TRAIL;
                end
                else if (!cls.digit_ok)
                begin
                    phase_next = PH_BAD;
                end
                else
                begin
                    phase_next = PH_BODY;
                    do_acc     = 1'b1;
                end
            end
            PH_TRAIL:
            begin
                if (cls.is_nul)
                begin
                    phase_next = PH_ENDED;
                end
                else if (!cls.is_space)
                begin
                    phase_next = PH_BAD;
                end
            end
            default: phase_next = PH_BAD;
        endcase

        acc_next = do_acc ? step_acc : acc_reg;
        sat_next = do_acc ? step_sat : sat_reg;
        bad      = (phase_next == PH_BAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_LEAD;
            radix_reg     <= RADIX_DEC;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            if (chars.ready)
            begin
                in_valid_reg <= chars.valid;
            end
            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                if (in_last_reg)
                begin
                    phase_reg <= PH_LEAD;
                    radix_reg <= RADIX_DEC;
                    acc_reg   <= '0;
                    sat_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    radix_reg <= radix_next;
                    acc_reg   <= acc_next;
                    sat_reg   <= sat_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            in_char_reg <= chars.char_code;
            in_last_reg <= chars.is_last;
        end
        if (advance && in_last_reg)
        begin
            out_status_reg <= bad;
            out_value_reg  <= bad ? '0 : (sat_next ? ValueMax : acc_next);
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.status = out_status_reg;
    assign result.value  = out_value_reg;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> result.valid)
        else $error("last beat did not produce a result");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (phase_reg == PH_LEAD && acc_reg == '0 && !sat_reg))
        else $error("parse state not cleared after a string");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (acc_reg == ValueMax))
        else $error("saturated without maximum value");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status) |-> (result.value == '0))
        else $error("invalid result carries a nonzero value");

    a_no_input_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_char_reg)))
        else $error("held character lost");

endmodule

[verif/ilp_literal_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilp_literal_checker
// Watches the character and result channels of the literal parser, predicts
// the status and value of every string from the accepted characters, and
// compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module ilp_literal_checker (
    input  logic  clk,
    input  logic  rst_n,
    ilp_char_if   chars,
    ilp_result_if result,
    output int    errors,
    output int    pending,
    output int    checked,
    output int    invalid_seen,
    output int    saturated_seen
);
    import ilp_pkg::*;

    localparam int BaseDec = 10;
    localparam int BaseOct = 8;
    localparam int BaseHex = 16;
    localparam logic [4:0] NotDigit = 5'd16;

    typedef struct packed {
        logic                  status;
        logic [ValueWidth-1:0] value;
    } parse_result_t;

    parse_result_t results_due[$];

    phase_t                lit_phase;
    radix_t                lit_radix;
    logic [ValueWidth-1:0] lit_acc;
    logic                  lit_sat;

    function automatic logic is_space(input logic [7:0] c);
        return (c >= CharTab && c <= CharCr) || c == CharSpace;
    endfunction

    function automatic int base_of(input radix_t r);
        if (r == RADIX_HEX) return BaseHex;
        if (r == RADIX_OCT) return BaseOct;
        return BaseDec;
    endfunction

    function automatic logic [4:0] digit_value(input logic [7:0] c, input int base);
        logic [4:0] d;
        d = NotDigit;
        if (c >= CharZero && c <= CharNine) d = 5'(c - CharZero);
        else if (c >= CharLowA && c <= CharLowF) d = 5'(c - CharLowA + DigitTen);
        else if (c >= CharUpA && c <= CharUpF) d = 5'(c - CharUpA + DigitTen);
        if (base == BaseOct && c > CharSeven) d = NotDigit;
        return (int'(d) < base) ? d : NotDigit;
    endfunction

    task automatic clear_literal();
        lit_phase = PH_LEAD;
        lit_radix = RADIX_DEC;
        lit_acc   = '0;
        lit_sat   = 1'b0;
    endtask

    // once past 2^63-1 the value sticks at the maximum
    task automatic add_digit(input logic [4:0] d);
        logic [63:0] base;
        logic [63:0] headroom;
        base = 64'(base_of(lit_radix));
        headroom = ({1'b0, ValueMax} - 64'(d)) / base;
        if (!lit_sat) begin
            if ({1'b0, lit_acc} > headroom) begin
                lit_sat = 1'b1;
                lit_acc = ValueMax;
            end
            else begin
                lit_acc = ValueWidth'({1'b0, lit_acc} * base + 64'(d));
            end
        end
    endtask

    task automatic take_char(input logic [7:0] c);
        logic       sp;
        logic [4:0] d;
        sp = is_space(c);
        case (lit_phase)
            PH_LEAD:
            begin
                if (!sp) begin
                    if (c == CharZero) begin
                        lit_phase = PH_ZERO;
                        lit_radix = RADIX_OCT;
                    end
                    else begin
                        d = digit_value(c, BaseDec);
                        if (d == NotDigit) lit_phase = PH_BAD;
                        else begin
                            lit_radix = RADIX_DEC;
                            lit_phase = PH_BODY;
                            add_digit(d);
                        end
                    end
                end
            end
            PH_ZERO:
            begin
                if (sp) lit_phase = PH_TRAIL;
                else if (c == CharLowX || c == CharUpX) begin
                    lit_phase = PH_HEXPFX;
                    lit_radix = RADIX_HEX;
                end
                else begin
                    d = digit_value(c, BaseOct);
                    if (d == NotDigit) lit_phase = PH_BAD;
                    else begin
                        lit_phase = PH_BODY;
                        add_digit(d);
                    end
                end
            end
            PH_HEXPFX, PH_BODY:
            begin
                if (sp) lit_phase = PH_TRAIL;
                else begin
                    d = digit_value(c, base_of(lit_radix));
                    if (d == NotDigit) lit_phase = PH_BAD;
                    else begin
                        lit_phase = PH_BODY;
                        add_digit(d);
                    end
                end
            end
            PH_TRAIL:
            begin
                if (!sp) lit_phase = PH_BAD;
            end
            PH_ENDED:
            begin
            end
            default:
            begin
                lit_phase = PH_BAD;
            end
        endcase
    endtask

    task automatic take_beat(input logic [7:0] c, input logic last);
        parse_result_t r;
        if (lit_phase != PH_BAD && lit_phase != PH_ENDED) begin
            if (c == CharNul) lit_phase = PH_ENDED;
            else take_char(c);
        end
        if (last) begin
            r.status = (lit_phase == PH_BAD);
            r.value  = r.status ? '0 : lit_acc;
            if (r.status) invalid_seen++;
            else if (lit_sat) saturated_seen++;
            results_due.push_back(r);
            clear_literal();
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        parse_result_t want;
        if (!rst_n) begin
            clear_literal();
            results_due.delete();
            errors         = 0;
            pending        = 0;
            checked        = 0;
            invalid_seen   = 0;
            saturated_seen = 0;
        end
        else begin
            if (result.valid && result.ready) begin
                if (results_due.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with none due, expected nothing, actual status %0d value %0d",
                             $time, result.status, result.value);
                end
                else begin
                    want = results_due.pop_front();
                    checked++;
                    if (result.status !== want.status) begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, result.status);
                    end
                    if (result.value !== want.value) begin
                        errors++;
                        $display("%0t: value mismatch, expected %0d, actual %0d",
                                 $time, want.value, result.value);
                    end
                end
            end
            if (chars.valid && chars.ready) take_beat(chars.char_code, chars.is_last);
            pending = results_due.size();
        end
    end

endmodule

[verif/integer_literal_parser_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_literal_parser_unit_test
// Streams directed and random literal strings into the parser with random
// gaps and result back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module integer_literal_parser_unit_test;
    import ilp_pkg::*;

    localparam int ItemTarget = 1200;
    localparam int CycleLimit = 400000;
    localparam int HoldCycles = 300;
    localparam int DrainCycles = 8;

    typedef logic [7:0] text_t[$];

    logic clk;
    logic rst_n;

    ilp_char_if   chars ();
    ilp_result_if result ();

    int errors;
    int pending;
    int checked;
    int invalid_seen;
    int saturated_seen;

    int chars_sent;
    int strings_sent;
    int cycles;
    bit no_idle;
    bit sender_steady;
    bit hold_req;
    bit hold_done;
    bit mid_drained;

    integer_literal_parser_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .result (result)
    );

    ilp_literal_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .chars          (chars),
        .result         (result),
        .errors         (errors),
        .pending        (pending),
        .checked        (checked),
        .invalid_seen   (invalid_seen),
        .saturated_seen (saturated_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycles, pending);
        $display("Verification failed");
        $finish;
    end

    function automatic text_t from_text(input string t);
        text_t s;
        for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
        return s;
    endfunction

    function automatic logic [7:0] space_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CharSpace : CharTab + 8'(k);
    endfunction

    function automatic logic [7:0] digit_char(input int v, input bit upper);
        if (v < 10) return CharZero + 8'(v);
        return (upper ? CharUpA : CharLowA) + 8'(v - 10);
    endfunction

    // mostly well-formed literals; some cut by a zero byte, some with one
    // byte smashed, some pure noise
    function automatic text_t random_literal();
        text_t s;
        int    kind;
        int    len;
        int    radix;
        kind  = $urandom_range(0, 99);
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 8);
        radix = $urandom_range(0, 2);
        repeat ($urandom_range(0, 2)) s.push_back(space_char());
        if (radix == 0)
        begin
            s.push_back(digit_char($urandom_range(1, 9), 1'b0));
            repeat (len - 1) s.push_back(digit_char($urandom_range(0, 9), 1'b0));
        end
        else if (radix == 1)
        begin
            s.push_back(CharZero);
            repeat (len - 1) s.push_back(digit_char($urandom_range(0, 7), 1'b0));
        end
        else
        begin
            s.push_back(CharZero);
            s.push_back($urandom_range(0, 1) ? CharUpX : CharLowX);
            repeat (len) s.push_back(digit_char($urandom_range(0, 15), $urandom_range(0, 1)));
        end
        repeat ($urandom_range(0, 2)) s.push_back(space_char());
        if (kind < 10)
        begin
            s.push_back(CharNul);
            repeat ($urandom_range(0, 2)) s.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind < 25)
        begin
            s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else if (kind < 35)
        begin
            s.delete();
            repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
        end
        return s;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_beat(input logic [7:0] c, input logic last);
        if (!no_idle && !sender_steady && $urandom_range(0, 3) == 0)
        begin
            chars.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        chars.valid     <= 1'b1;
        chars.char_code <= c;
        chars.is_last   <= last;
        do @(posedge clk); while (!chars.ready);
        @(negedge clk);
        chars_sent++;
        if (chars_sent >= ItemTarget - 150) no_idle = 1'b1;
    endtask

    task automatic send_string(input text_t s);
        foreach (s[i]) send_beat(s[i], i == s.size() - 1);
        strings_sent++;
    endtask

    task automatic drain_results();
        chars.valid <= 1'b0;
        wait (pending == 0);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // result side: random stalls, plus one long hold on request
    initial
    begin
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result.ready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
                hold_req  = 1'b0;
                hold_done = 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 4) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        text_t s;
        chars.valid     = 1'b0;
        chars.char_code = CharNul;
        chars.is_last   = 1'b0;
        rst_n           = 1'b0;
        chars_sent      = 0;
        strings_sent    = 0;
        no_idle         = 1'b0;
        sender_steady   = 1'b0;
        hold_req        = 1'b0;
        hold_done       = 1'b0;
        mid_drained     = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty string, all space, lone zero, lone hex prefix, hex with F/f
        s = {};
        s.push_back(CharNul);
        send_string(s);
        send_string(from_text(" \v"));
        send_string(from_text("0"));
        send_string(from_text("0X"));
        send_string(from_text("0xfF"));
        // sign, high code, bad octal digit, space inside the body
        send_string(from_text("-7"));
        s = {};
        s.push_back(8'hFF);
        send_string(s);
        send_string(from_text("08"));
        send_string(from_text("1 2"));
        // junk after a zero byte is ignored
        s = from_text("5");
        s.push_back(CharNul);
        s.push_back(8'h7A);
        send_string(s);
        send_string(from_text("777\f"));
        drain_results();

        while (chars_sent < ItemTarget)
        begin
            if (!hold_done && chars_sent >= ItemTarget / 4)
            begin
                // fill the block while results are held back
                sender_steady = 1'b1;
                hold_req      = 1'b1;
                repeat (30) send_string(from_text("7"));
                wait (hold_done);
                sender_steady = 1'b0;
            end
            if (!mid_drained && chars_sent >= ItemTarget / 2)
            begin
                mid_drained = 1'b1;
                drain_results();
            end
            send_string(random_literal());
        end
        drain_results();

        $display("%0d strings in %0d characters, %0d results checked",
                 strings_sent, chars_sent, checked);
        $display("%0d strings rejected, %0d saturated", invalid_seen, saturated_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/ilp_pkg.sv
rtl/ilp_if.sv
rtl/ilp_char_class.sv
rtl/ilp_accum.sv
rtl/integer_literal_parser_unit.sv
verif/ilp_literal_checker.sv
verif/integer_literal_parser_unit_test.sv
